// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is asserted
`define LCFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcfs assertion failed");

// property checked on every rising edge, reset included
`define LCFS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lcfs assertion failed");

`endif

// File: src/lcfs_pkg.sv
// types and constants of the launcher cocking and fire sequencer
package lcfs_pkg;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_HOLD   = 3'd1,
        MODE_RESET  = 3'd2,
        MODE_COCKED = 3'd3,
        MODE_FIRE   = 3'd4
    } t_mode;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_RESET_TICKS  = 2'd0,
        REG_LAUNCH_TICKS = 2'd1,
        REG_SLOW_DRIVE   = 2'd2
    } t_reg_idx;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [TICK_W-1:0]         TICKS_MAX     = '1;
    localparam logic signed [DRIVE_W-1:0] FULL_REVERSE  = -8'sd127;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RAW = -8'sd128;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STOP    = 8'sd0;

    localparam logic [TICK_W-1:0]         RESET_TICKS_INIT  = 16'd50;
    localparam logic [TICK_W-1:0]         LAUNCH_TICKS_INIT = 16'd25;
    localparam logic signed [DRIVE_W-1:0] SLOW_DRIVE_INIT   = -8'sd40;

    typedef struct packed {
        logic trigger_pressed;
        logic safety_pressed;
        logic kill_a;
        logic kill_b;
        logic arm_ready;
        logic pulse_switch;
    } t_fields;

    typedef struct packed {
        logic [TICK_W-1:0]         reset_ticks;
        logic [TICK_W-1:0]         launch_ticks;
        logic signed [DRIVE_W-1:0] slow_drive;
    } t_cfg;

    typedef struct packed {
        t_mode                     mode;
        logic                      press_latched;
        logic                      pulse_seen;
        logic [TICK_W-1:0]         ticks_in_mode;
        logic signed [DRIVE_W-1:0] held_drive;
    } t_state;

endpackage

// File: src/lcfs_if.sv
// valid/ready channels for input words and result words
interface lcfs_in_if;
    logic valid;
    logic ready;
    logic trigger_pressed;
    logic safety_pressed;
    logic kill_a;
    logic kill_b;
    logic arm_ready;
    logic pulse_switch;

    modport source (
        output valid, trigger_pressed, safety_pressed, kill_a, kill_b, arm_ready,
               pulse_switch,
        input  ready
    );
    modport sink (
        input  valid, trigger_pressed, safety_pressed, kill_a, kill_b, arm_ready,
               pulse_switch,
        output ready
    );
endinterface

interface lcfs_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] drive_value;
    logic [2:0]        mode_code;

    modport source (
        output valid, drive_value, mode_code,
        input  ready
    );
    modport sink (
        input  valid, drive_value, mode_code,
        output ready
    );
endinterface

// File: src/lcfs_step.sv
// next-state logic for one control tick
module lcfs_step (
    input  lcfs_pkg::t_state  i_state,
    input  lcfs_pkg::t_fields i_fields,
    input  lcfs_pkg::t_cfg    i_cfg,
    output lcfs_pkg::t_state  o_state
);

    logic                             kill;
    logic                             combo;
    logic                             buttons_free;
    logic signed [lcfs_pkg::DRIVE_W-1:0] slow_sat;

    assign kill         = i_fields.kill_a && i_fields.kill_b;
    assign combo        = i_fields.trigger_pressed && i_fields.safety_pressed;
    assign buttons_free = !i_fields.trigger_pressed && !i_fields.safety_pressed;
    assign slow_sat     = (i_cfg.slow_drive == lcfs_pkg::DRIVE_MIN_RAW) ?
                          lcfs_pkg::FULL_REVERSE : i_cfg.slow_drive;

    always_comb begin
        lcfs_pkg::t_mode nxt;
        logic            latch;
        logic            seen;
        logic signed [lcfs_pkg::DRIVE_W-1:0] drive;

        nxt   = i_state.mode;
        latch = i_state.press_latched;
        seen  = i_state.pulse_seen;
        drive = i_state.held_drive;

        case (i_state.mode)
            lcfs_pkg::MODE_OFF: begin
                drive = lcfs_pkg::DRIVE_STOP;
                if (latch && !i_fields.kill_a && !i_fields.kill_b) begin
                    latch = 1'b0;
                end
                if (kill && !latch) begin
                    latch = 1'b1;
                    nxt   = lcfs_pkg::MODE_HOLD;
                end
            end
            lcfs_pkg::MODE_HOLD: begin
                drive = lcfs_pkg::DRIVE_STOP;
                if (latch && buttons_free) begin
                    latch = 1'b0;
                end
                if (combo && !latch) begin
                    latch = 1'b1;
                    nxt   = lcfs_pkg::MODE_RESET;
                end
                if (kill) begin
                    nxt = lcfs_pkg::MODE_OFF;
                end
            end
            lcfs_pkg::MODE_RESET: begin
                drive = (i_state.ticks_in_mode < i_cfg.reset_ticks) ?
                        lcfs_pkg::FULL_REVERSE : slow_sat;
                if (i_fields.pulse_switch) begin
                    seen = 1'b1;
                end
                if (!i_fields.pulse_switch && seen) begin
                    nxt = lcfs_pkg::MODE_COCKED;
                end
                if (kill) begin
                    nxt = lcfs_pkg::MODE_OFF;
                end
                if (nxt != lcfs_pkg::MODE_RESET) begin
                    seen = 1'b0;
                end
            end
            lcfs_pkg::MODE_COCKED: begin
                drive = lcfs_pkg::DRIVE_STOP;
                if (latch && buttons_free) begin
                    latch = 1'b0;
                end
                if (combo && !latch && i_fields.arm_ready) begin
                    latch = 1'b1;
                    nxt   = lcfs_pkg::MODE_FIRE;
                end
                if (kill) begin
                    nxt = lcfs_pkg::MODE_OFF;
                end
            end
            lcfs_pkg::MODE_FIRE: begin
                if (i_state.ticks_in_mode < i_cfg.launch_ticks) begin
                    drive = lcfs_pkg::FULL_REVERSE;
                end else begin
                    nxt = lcfs_pkg::MODE_HOLD;
                end
                if (kill) begin
                    nxt = lcfs_pkg::MODE_OFF;
                end
            end
            default: begin
                nxt = lcfs_pkg::MODE_OFF;
            end
        endcase

        o_state.mode          = nxt;
        o_state.press_latched = latch;
        o_state.pulse_seen    = seen;
        o_state.held_drive    = drive;
        if (nxt != i_state.mode) begin
            o_state.ticks_in_mode = '0;
        end else if (i_state.ticks_in_mode != lcfs_pkg::TICKS_MAX) begin
            o_state.ticks_in_mode = i_state.ticks_in_mode + 1'b1;
        end else begin
            o_state.ticks_in_mode = i_state.ticks_in_mode;
        end
    end

endmodule

// File: src/launcher_cocking_fire_sequencer_unit.sv
// top level of the launcher cocking and fire sequencer
// an accepted word goes into the input register, its result word then into the result register
// throughput: one word per cycle while the receiver takes result words, set by the mode update
//   between the input register and the result register
// reset (i_rst_n low, synchronous): mode hold, press latch set, pulse latch
//   and tick count cleared, drive held at 0, registers back to defaults
module launcher_cocking_fire_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lcfs_in_if.sink                       i_in,
    lcfs_out_if.source                    o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [lcfs_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [lcfs_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [lcfs_pkg::PDATA_W-1:0]  o_prdata,
    output logic                          o_pready
);

    // configuration registers
    lcfs_pkg::t_cfg     r_cfg;
    lcfs_pkg::t_reg_idx reg_idx;
    logic               cfg_wr;

    // input stage: one word held while the mode update waits on the output
    logic               r_in_valid;
    lcfs_pkg::t_fields  r_in;
    lcfs_pkg::t_fields  in_fields;

    // sequencer state and result register
    lcfs_pkg::t_state   r_state;
    lcfs_pkg::t_state   n_state;
    logic               r_out_valid;
    logic signed [lcfs_pkg::DRIVE_W-1:0] r_out_drive;
    lcfs_pkg::t_mode    r_out_mode;

    logic               advance;
    logic               in_ready;

    // apb side, always ready, register picked by word address
    assign o_pready = 1'b1;
    assign reg_idx  = lcfs_pkg::t_reg_idx'(i_paddr[3:2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_ticks  <= lcfs_pkg::RESET_TICKS_INIT;
            r_cfg.launch_ticks <= lcfs_pkg::LAUNCH_TICKS_INIT;
            r_cfg.slow_drive   <= lcfs_pkg::SLOW_DRIVE_INIT;
        end else if (cfg_wr) begin
            case (reg_idx)
                lcfs_pkg::REG_RESET_TICKS: begin
                    r_cfg.reset_ticks <= i_pwdata[lcfs_pkg::TICK_W-1:0];
                end
                lcfs_pkg::REG_LAUNCH_TICKS: begin
                    r_cfg.launch_ticks <= i_pwdata[lcfs_pkg::TICK_W-1:0];
                end
                lcfs_pkg::REG_SLOW_DRIVE: begin
                    r_cfg.slow_drive <= i_pwdata[lcfs_pkg::DRIVE_W-1:0];
                end
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lcfs_pkg::REG_RESET_TICKS: begin
                o_prdata = {{(lcfs_pkg::PDATA_W-lcfs_pkg::TICK_W){1'b0}},
                            r_cfg.reset_ticks};
            end
            lcfs_pkg::REG_LAUNCH_TICKS: begin
                o_prdata = {{(lcfs_pkg::PDATA_W-lcfs_pkg::TICK_W){1'b0}},
                            r_cfg.launch_ticks};
            end
            lcfs_pkg::REG_SLOW_DRIVE: begin
                o_prdata = {{(lcfs_pkg::PDATA_W-lcfs_pkg::DRIVE_W){1'b0}},
                            r_cfg.slow_drive};
            end
            default: begin
                o_prdata = '0;
            end
        endcase
    end

    // pipeline control: the result register moves when empty or taken,
    // the input register moves when empty or when its word moves on
    assign advance    = !r_out_valid || o_out.ready;
    assign in_ready   = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    assign in_fields.trigger_pressed = i_in.trigger_pressed;
    assign in_fields.safety_pressed  = i_in.safety_pressed;
    assign in_fields.kill_a          = i_in.kill_a;
    assign in_fields.kill_b          = i_in.kill_b;
    assign in_fields.arm_ready       = i_in.arm_ready;
    assign in_fields.pulse_switch    = i_in.pulse_switch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= in_fields;
        end
    end

    // one control tick of the mode sequencer
    lcfs_step u_step (
        .i_state  (r_state),
        .i_fields (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state)
    );

    // state commits only when the tick's result word is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= lcfs_pkg::MODE_HOLD;
            r_state.press_latched <= 1'b1;
            r_state.pulse_seen    <= 1'b0;
            r_state.ticks_in_mode <= '0;
            r_state.held_drive    <= lcfs_pkg::DRIVE_STOP;
            r_out_valid           <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_drive <= n_state.held_drive;
            r_out_mode  <= n_state.mode;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_value = r_out_drive;
    assign o_out.mode_code   = r_out_mode;

endmodule

// File: src/lcfs_checker.sv
// port-level checks of the sequencer, bound to the top level
`include "assert_macros.svh"

module lcfs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [7:0]            i_out_drive,
    input logic [2:0]                   i_out_mode,
    input logic                         i_pready
);

    logic        out_stall;
    logic        in_take;
    logic [10:0] out_word;

    assign out_stall = i_out_valid && !i_out_ready;
    assign in_take   = i_in_valid && i_in_ready;
    assign out_word  = {i_out_drive, i_out_mode};

    // no result word right after reset
    `LCFS_ASSERT_ALWAYS(a_no_word_after_reset, i_clk, i_rst_n && $past(!i_rst_n) |-> !i_out_valid)

    // mode code stays within the five modes
    `LCFS_ASSERT(a_mode_range, i_clk, i_rst_n, i_out_valid |-> i_out_mode <= lcfs_pkg::MODE_FIRE)

    // a stalled result word holds
    `LCFS_ASSERT(a_out_hold, i_clk, i_rst_n, $past(out_stall) |-> i_out_valid && $stable(out_word))

    // with the input stage just filled and the output stalled, input backs off
    `LCFS_ASSERT(a_backpressure, i_clk, i_rst_n, out_stall && $past(in_take) |-> !i_in_ready)

    // config port never waits
    `LCFS_ASSERT(a_pready, i_clk, i_rst_n, i_pready)

endmodule

bind launcher_cocking_fire_sequencer_unit lcfs_checker u_lcfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive_value),
    .i_out_mode  (o_out.mode_code),
    .i_pready    (o_pready)
);

// File: verif/launcher_cocking_fire_sequencer_unit_tb.sv
// testbench for the launcher cocking and fire sequencer: directed table, random ticks, dwell
module launcher_cocking_fire_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word: motor command and mode after the tick
    typedef struct packed {
        logic signed [lcfs_pkg::DRIVE_W-1:0] drive;
        lcfs_pkg::t_mode                     mode;
    } t_motor_cmd;

    // one row of the directed table; pinned rows carry a hand-written result
    typedef struct packed {
        lcfs_pkg::t_fields                   w;
        logic                                pinned;
        logic signed [lcfs_pkg::DRIVE_W-1:0] drive;
        lcfs_pkg::t_mode                     mode;
    } t_dir_row;

    localparam int DIR_ROWS           = 30;
    localparam int SECOND_SETTING_ROW = 16;
    localparam int PHASE_WORDS        = 265;
    localparam int RANDOM_PHASES      = 6;
    localparam int IDLE_PCT           = 14;
    localparam int HOLDOFF_AT         = 700;
    localparam int HOLDOFF_CYCLES     = 64;
    localparam int DRAIN_SLACK        = 4;
    localparam int STUCK_LIMIT        = 1000;
    localparam int LONG_DWELL         = 40;
    localparam int PRINT_CAP          = 40;

    // short names for the table columns
    localparam logic signed [lcfs_pkg::DRIVE_W-1:0] D_STOP  = lcfs_pkg::DRIVE_STOP;
    localparam logic signed [lcfs_pkg::DRIVE_W-1:0] D_REV   = lcfs_pkg::FULL_REVERSE;
    localparam lcfs_pkg::t_mode                     M_OFF   = lcfs_pkg::MODE_OFF;
    localparam lcfs_pkg::t_mode                     M_HOLD  = lcfs_pkg::MODE_HOLD;
    localparam lcfs_pkg::t_mode                     M_RESET = lcfs_pkg::MODE_RESET;

    // directed setting a: one tick of full reverse, one tick of launch, raw slow drive of -128
    localparam lcfs_pkg::t_cfg SETTING_A = '{16'd1, 16'd1, lcfs_pkg::DRIVE_MIN_RAW};
    // directed setting b: zero tick counts, slow drive at full forward
    localparam lcfs_pkg::t_cfg SETTING_B = '{16'd0, 16'd0, 8'sd127};

    // trig, safe, kill_a, kill_b, arm, pulse
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{6'b000000, 1'b1, D_STOP, M_HOLD},    // out of reset, release clears latch
        '{6'b110000, 1'b0, D_STOP, M_OFF},     // trigger+safety starts cocking
        '{6'b000000, 1'b1, D_REV,  M_RESET},   // first cocking tick, full reverse
        '{6'b000001, 1'b1, D_REV,  M_RESET},   // slow drive -128 saturates, pulse high
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // pulse falls, cocked
        '{6'b110010, 1'b0, D_STOP, M_OFF},     // still latched, no fire
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // release
        '{6'b110000, 1'b0, D_STOP, M_OFF},     // arm not ready, no fire
        '{6'b110010, 1'b0, D_STOP, M_OFF},     // fire
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // launch tick
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // fire ends, drive held
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // hold stops the motor
        '{6'b111100, 1'b0, D_STOP, M_OFF},     // kill beats the cocking entry
        '{6'b001100, 1'b0, D_STOP, M_OFF},     // off, kill still held
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // release in off
        '{6'b001100, 1'b0, D_STOP, M_OFF},     // kill pair back to hold
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // setting b from here
        '{6'b110000, 1'b0, D_STOP, M_OFF},     // cocking
        '{6'b000001, 1'b0, D_STOP, M_OFF},     // zero reverse ticks, slow at once
        '{6'b001101, 1'b0, D_STOP, M_OFF},     // kill in cocking drops pulse latch
        '{6'b000000, 1'b0, D_STOP, M_OFF},
        '{6'b001100, 1'b0, D_STOP, M_OFF},
        '{6'b000000, 1'b0, D_STOP, M_OFF},
        '{6'b110000, 1'b0, D_STOP, M_OFF},     // cocking again
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // pulse latch was cleared, stays
        '{6'b000001, 1'b0, D_STOP, M_OFF},
        '{6'b000000, 1'b0, D_STOP, M_OFF},     // cocked
        '{6'b000000, 1'b0, D_STOP, M_OFF},
        '{6'b110010, 1'b0, D_STOP, M_OFF},     // fire
        '{6'b000000, 1'b0, D_STOP, M_OFF}      // zero launch ticks, fire ends at once
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_psel;
    logic                           i_penable;
    logic                           i_pwrite;
    logic [lcfs_pkg::PADDR_W-1:0]   i_paddr;
    logic [lcfs_pkg::PDATA_W-1:0]   i_pwdata;
    logic [lcfs_pkg::PDATA_W-1:0]   o_prdata;
    logic                           o_pready;

    lcfs_in_if  in_if();
    lcfs_out_if out_if();

    launcher_cocking_fire_sequencer_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // predicted sequencer state, own copy
    lcfs_pkg::t_mode                     seq_mode;
    logic                                await_release;
    logic                                cock_pulse_hi;
    logic [lcfs_pkg::TICK_W-1:0]         dwell;
    logic signed [lcfs_pkg::DRIVE_W-1:0] motor_hold;

    // predicted register contents
    logic [lcfs_pkg::TICK_W-1:0]         cfg_cock_len;
    logic [lcfs_pkg::TICK_W-1:0]         cfg_launch_len;
    logic signed [lcfs_pkg::DRIVE_W-1:0] cfg_creep;

    t_motor_cmd awaited_cmds [$];
    t_motor_cmd pinned_cmd;
    logic       pinned_valid;

    logic calm;
    int   mismatches;
    int   words_sent;
    int   cmds_checked;
    int   settings_done;
    int   mode_entries [5];
    int   holdoff_left;
    logic holdoff_done;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // one tick of the sequencer as seen from outside
    function automatic t_motor_cmd predict_tick(input lcfs_pkg::t_fields w);
        lcfs_pkg::t_mode                     nxt;
        logic                                both_kill;
        logic signed [lcfs_pkg::DRIVE_W-1:0] creep;
        t_motor_cmd                          cmd;
        both_kill = w.kill_a & w.kill_b;
        // raw -128 is not a legal drive, clamp to full reverse
        creep = (cfg_creep == lcfs_pkg::DRIVE_MIN_RAW) ? lcfs_pkg::FULL_REVERSE : cfg_creep;
        nxt = seq_mode;
        case (seq_mode)
            lcfs_pkg::MODE_OFF: begin
                motor_hold = lcfs_pkg::DRIVE_STOP;
                if (await_release && !w.kill_a && !w.kill_b) await_release = 1'b0;
                if (both_kill && !await_release) begin
                    await_release = 1'b1;
                    nxt = lcfs_pkg::MODE_HOLD;
                end
            end
            lcfs_pkg::MODE_HOLD: begin
                motor_hold = lcfs_pkg::DRIVE_STOP;
                if (await_release && !w.trigger_pressed && !w.safety_pressed)
                    await_release = 1'b0;
                if (w.trigger_pressed && w.safety_pressed && !await_release) begin
                    await_release = 1'b1;
                    nxt = lcfs_pkg::MODE_RESET;
                end
                if (both_kill) nxt = lcfs_pkg::MODE_OFF;
            end
            lcfs_pkg::MODE_RESET: begin
                motor_hold = (dwell < cfg_cock_len) ? lcfs_pkg::FULL_REVERSE : creep;
                if (w.pulse_switch) cock_pulse_hi = 1'b1;
                // falling edge of the cocking switch after a high level
                if (!w.pulse_switch && cock_pulse_hi) nxt = lcfs_pkg::MODE_COCKED;
                if (both_kill) nxt = lcfs_pkg::MODE_OFF;
                if (nxt != lcfs_pkg::MODE_RESET) cock_pulse_hi = 1'b0;
            end
            lcfs_pkg::MODE_COCKED: begin
                motor_hold = lcfs_pkg::DRIVE_STOP;
                if (await_release && !w.trigger_pressed && !w.safety_pressed)
                    await_release = 1'b0;
                if (w.trigger_pressed && w.safety_pressed && !await_release && w.arm_ready) begin
                    await_release = 1'b1;
                    nxt = lcfs_pkg::MODE_FIRE;
                end
                if (both_kill) nxt = lcfs_pkg::MODE_OFF;
            end
            lcfs_pkg::MODE_FIRE: begin
                // the closing tick commands nothing, the motor keeps its value
                if (dwell < cfg_launch_len) motor_hold = lcfs_pkg::FULL_REVERSE;
                else nxt = lcfs_pkg::MODE_HOLD;
                if (both_kill) nxt = lcfs_pkg::MODE_OFF;
            end
            default: begin
                nxt = lcfs_pkg::MODE_OFF;
            end
        endcase
        if (nxt != seq_mode) begin
            dwell = '0;
            mode_entries[int'(nxt)]++;
        end else if (dwell != lcfs_pkg::TICKS_MAX) begin
            dwell = dwell + 1'b1;
        end
        seq_mode = nxt;
        cmd.drive = motor_hold;
        cmd.mode = seq_mode;
        return cmd;
    endfunction

    // random tick shaped by the predicted mode so that sequences get deep
    function automatic lcfs_pkg::t_fields pick_tick();
        lcfs_pkg::t_fields w;
        int unsigned       roll;
        roll = $urandom_range(99);
        w = '0;
        if (roll < 15) begin
            // plain noise
            w = lcfs_pkg::t_fields'(6'($urandom));
        end else begin
            w.arm_ready = ($urandom_range(9) < 7);
            case (seq_mode)
                lcfs_pkg::MODE_OFF: begin
                    if (await_release) begin
                        if ($urandom_range(9) < 3) {w.kill_a, w.kill_b} = 2'($urandom);
                    end else if ($urandom_range(9) < 6) begin
                        {w.kill_a, w.kill_b} = 2'b11;
                    end else begin
                        {w.kill_a, w.kill_b} = 2'($urandom);
                    end
                end
                lcfs_pkg::MODE_HOLD, lcfs_pkg::MODE_COCKED: begin
                    if (await_release) begin
                        if ($urandom_range(9) < 3)
                            {w.trigger_pressed, w.safety_pressed} = 2'($urandom);
                    end else if ($urandom_range(9) < 5) begin
                        {w.trigger_pressed, w.safety_pressed} = 2'b11;
                    end else begin
                        {w.trigger_pressed, w.safety_pressed} = 2'($urandom);
                    end
                end
                lcfs_pkg::MODE_RESET: begin
                    // switch mostly low, short highs
                    w.pulse_switch = ($urandom_range(99) < 20);
                    {w.trigger_pressed, w.safety_pressed} = 2'($urandom);
                end
                default: begin
                    {w.trigger_pressed, w.safety_pressed} = 2'($urandom);
                end
            endcase
            // occasional kill, pair or single
            if (roll >= 95) {w.kill_a, w.kill_b} = 2'b11;
            else if (roll >= 92) {w.kill_a, w.kill_b} = 2'($urandom);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d want %0d", cmds_checked, what, got,
                     want);
    endtask

    // offer one word, called and returning at a falling edge
    task automatic send_word(input lcfs_pkg::t_fields w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.trigger_pressed <= w.trigger_pressed;
        in_if.safety_pressed  <= w.safety_pressed;
        in_if.kill_a          <= w.kill_a;
        in_if.kill_b          <= w.kill_b;
        in_if.arm_ready       <= w.arm_ready;
        in_if.pulse_switch    <= w.pulse_switch;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // apb write: setup, access, then the bus is left quiet
    task automatic apb_write(input lcfs_pkg::t_reg_idx idx,
                             input logic [lcfs_pkg::PDATA_W-1:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop offering, let every result drain, then load a new register setting
    task automatic quiesce_and_configure(input lcfs_pkg::t_cfg c);
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (awaited_cmds.size() != 0);
        repeat (DRAIN_SLACK) @(negedge i_clk);
        apb_write(lcfs_pkg::REG_RESET_TICKS, lcfs_pkg::PDATA_W'(c.reset_ticks));
        apb_write(lcfs_pkg::REG_LAUNCH_TICKS, lcfs_pkg::PDATA_W'(c.launch_ticks));
        apb_write(lcfs_pkg::REG_SLOW_DRIVE,
                  {{(lcfs_pkg::PDATA_W-lcfs_pkg::DRIVE_W){1'b0}}, c.slow_drive});
        cfg_cock_len   = c.reset_ticks;
        cfg_launch_len = c.launch_ticks;
        cfg_creep      = c.slow_drive;
        settings_done++;
    endtask

    // input side: every accepted word advances the prediction
    always @(posedge i_clk) begin
        t_motor_cmd        cmd;
        lcfs_pkg::t_fields w;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            w = {in_if.trigger_pressed, in_if.safety_pressed, in_if.kill_a, in_if.kill_b,
                 in_if.arm_ready, in_if.pulse_switch};
            cmd = predict_tick(w);
            // pinned table rows carry their result by hand
            if (pinned_valid) begin
                cmd = pinned_cmd;
                pinned_valid = 1'b0;
            end
            awaited_cmds.push_back(cmd);
            words_sent++;
        end
    end

    // result side: oldest expectation against each accepted result word
    always @(posedge i_clk) begin
        t_motor_cmd want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_cmds.size() == 0) begin
                report_mismatch("result with nothing awaited, drive", int'(out_if.drive_value),
                                0);
            end else begin
                want = awaited_cmds.pop_front();
                if (out_if.drive_value !== want.drive)
                    report_mismatch("drive_value", int'(out_if.drive_value), int'(want.drive));
                if (out_if.mode_code !== want.mode)
                    report_mismatch("mode_code", int'(out_if.mode_code), int'(want.mode));
            end
            cmds_checked++;
        end
    end

    // receiver: random stalls, one long hold-off so the block backs up into its input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            out_if.ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && cmds_checked >= HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: too long without any word moving on either side
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
        $display("launcher_cocking_fire_sequencer_unit test failed");
        $finish;
    end

    initial begin
        lcfs_pkg::t_cfg    setting;
        lcfs_pkg::t_fields w;

        // everything known from time zero
        i_rst_n               = 1'b0;
        i_psel                = 1'b0;
        i_penable             = 1'b0;
        i_pwrite              = 1'b0;
        i_paddr               = '0;
        i_pwdata              = '0;
        in_if.valid           = 1'b0;
        in_if.trigger_pressed = 1'b0;
        in_if.safety_pressed  = 1'b0;
        in_if.kill_a          = 1'b0;
        in_if.kill_b          = 1'b0;
        in_if.arm_ready       = 1'b0;
        in_if.pulse_switch    = 1'b0;
        out_if.ready          = 1'b0;

        seq_mode       = lcfs_pkg::MODE_HOLD;
        await_release  = 1'b1;
        cock_pulse_hi  = 1'b0;
        dwell          = '0;
        motor_hold     = lcfs_pkg::DRIVE_STOP;
        cfg_cock_len   = lcfs_pkg::RESET_TICKS_INIT;
        cfg_launch_len = lcfs_pkg::LAUNCH_TICKS_INIT;
        cfg_creep      = lcfs_pkg::SLOW_DRIVE_INIT;
        pinned_valid   = 1'b0;
        pinned_cmd     = '0;
        calm           = 1'b0;
        mismatches     = 0;
        words_sent     = 0;
        cmds_checked   = 0;
        settings_done  = 0;
        holdoff_left   = 0;
        holdoff_done   = 1'b0;
        foreach (mode_entries[m]) mode_entries[m] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        quiesce_and_configure(SETTING_A);
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == SECOND_SETTING_ROW) quiesce_and_configure(SETTING_B);
            if (DIRECTED_ROWS[i].pinned) begin
                pinned_cmd.drive = DIRECTED_ROWS[i].drive;
                pinned_cmd.mode  = DIRECTED_ROWS[i].mode;
                pinned_valid     = 1'b1;
            end
            send_word(DIRECTED_ROWS[i].w);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: setting = '{16'd3, 16'd2, -8'sd40};
                1: setting = '{16'd0, 16'd0, 8'sd127};
                3: setting = '{lcfs_pkg::TICKS_MAX, lcfs_pkg::TICKS_MAX,
                               lcfs_pkg::DRIVE_MIN_RAW};
                5: setting = '{16'd5, 16'd4, -8'sd1};
                default: setting = '{16'($urandom_range(7)), 16'($urandom_range(7)),
                                     8'($urandom)};
            endcase
            quiesce_and_configure(setting);
            // one phase with no idling on either side
            calm = (ph == 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // sender pause until every result is back
                if (ph == 4 && n == PHASE_WORDS / 2) begin
                    in_if.valid <= 1'b0;
                    do @(negedge i_clk); while (awaited_cmds.size() != 0);
                end
                send_word(pick_tick());
            end
        end

        // dwell in cocking past the reverse time, into the slow drive
        quiesce_and_configure('{16'd20, 16'd3, -8'sd40});
        calm = 1'b1;
        while (seq_mode != lcfs_pkg::MODE_RESET) begin
            w = '0;
            case (seq_mode)
                lcfs_pkg::MODE_OFF: begin
                    if (!await_release) {w.kill_a, w.kill_b} = 2'b11;
                end
                lcfs_pkg::MODE_HOLD: begin
                    if (!await_release) {w.trigger_pressed, w.safety_pressed} = 2'b11;
                end
                default: begin
                    {w.kill_a, w.kill_b} = 2'b11;
                end
            endcase
            send_word(w);
        end
        repeat (LONG_DWELL) send_word('0);
        send_word(lcfs_pkg::t_fields'(6'b000001));
        send_word('0);

        // drain, then keep watching for anything stray
        in_if.valid <= 1'b0;
        while (awaited_cmds.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (awaited_cmds.size() != 0)
            report_mismatch("results never delivered", awaited_cmds.size(), 0);

        $display("run covered %0d input words and %0d result words over %0d register settings",
                 words_sent, cmds_checked, settings_done);
        $display("modes entered: off %0d, hold %0d, cocking %0d, cocked %0d, fire %0d",
                 mode_entries[0], mode_entries[1], mode_entries[2], mode_entries[3],
                 mode_entries[4]);
        if (mismatches == 0) begin
            $display("launcher_cocking_fire_sequencer_unit test passed");
        end else begin
            $display("launcher_cocking_fire_sequencer_unit test failed");
        end
        $finish;
    end

endmodule
